// ===== design/fmm_pkg.sv =====
// Shared types, widths and constants of the FM baseband modulator.
// Used by fmm_step_gen, fmm_cordic_cell and fm_baseband_modulator.
// Depends on nothing.
`default_nettype none

package fmm_pkg;

  // Field and state widths.
  localparam int SAMPLE_W      = 16;
  localparam int PHASE_W       = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int GAIN_W        = 16;
  localparam int DEV_W         = 28;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 28;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(205);
  localparam logic [DEV_W-1:0]  DEV_RESET  = DEV_W'(873813);

  // Amplitude scaling: Q1.15 magnitude times Q8.8 gain, rounded back to Q1.15.
  localparam int MAG_W      = SAMPLE_W + 1;
  localparam int AMP_PROD_W = MAG_W + GAIN_W + 1;
  localparam int GAIN_FRAC  = 8;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'(1) << (SAMPLE_W - 1);

  // Phase step: amplitude times deviation, aligned to the phase LSB.
  localparam int DEV_FRAC    = 24;
  localparam int STEP_SH     = (SAMPLE_W - 1) + DEV_FRAC - PHASE_W;
  localparam int STEP_RSH    = (STEP_SH > 0) ? STEP_SH : 0;
  localparam int STEP_LSH    = (STEP_SH < 0) ? -STEP_SH : 0;
  localparam int STEP_PROD_W = SAMPLE_W + DEV_W + 1;
  localparam int STEP_WIDE_W = STEP_PROD_W + STEP_LSH + PHASE_W;

  // CORDIC datapath.
  localparam int ANG_W      = 32;
  localparam int STAGE_MAX  = 24;
  localparam int IDX_W      = $clog2(STAGE_MAX);
  localparam int CORDIC_FRAC = 30;
  localparam int XY_W       = CORDIC_FRAC + 3;
  localparam int Z_W        = ANG_W + 2;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);
  localparam int OUT_SH     = CORDIC_FRAC - (SAMPLE_W - 1);
  localparam logic signed [XY_W-1:0] OUT_RND = XY_W'(1) <<< (OUT_SH - 1);
  localparam logic signed [XY_W-1:0] OUT_LIM = (XY_W'(1) <<< (SAMPLE_W - 1)) - XY_W'(1);

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [ANG_W-1:0] ATAN_TURNS [STAGE_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 2'd0,
    CFG_DEVIATION = 2'd1
  } cfg_reg_e;

  // Phase step handed from the step generator to the accumulator.
  typedef struct packed {
    logic               valid;
    logic               neg;
    logic [PHASE_W-1:0] step;
  } step_t;

  // Vector handed from one CORDIC cell to the next.
  typedef struct packed {
    logic                   valid;
    logic                   flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

endpackage

`default_nettype wire

// ===== design/fm_baseband_modulator.sv =====
// Top level of the FM baseband modulator: configuration registers, phase
// accumulator, CORDIC cell chain and output register.
// Depends on fmm_pkg, fmm_step_gen and fmm_cordic_cell.
//
// Usage:
// The input channel (in_valid_i, in_stall_o, audio_sample_i) takes one signed
// Q1.15 audio sample per transaction. The output channel (out_valid_o,
// out_stall_i, out_i_o, out_q_o) returns exactly one I/Q pair per sample, in
// order, with I the sine and Q the cosine of the updated phase, both Q1.15.
// The whole datapath is one pipeline that moves forward as one: two stages
// for the gain and deviation multiplies, one for the phase accumulator, one
// CORDIC cell per rotation (CORDIC_STAGES cells), and the output register.
// One sample is accepted every cycle unless the pipeline is frozen; only
// the phase add closes a loop, through the accumulator register.
// When the receiver stalls while a result waits, the whole pipeline freezes
// and in_stall_o is raised in the same cycle; no transaction is dropped.
// Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// are always accepted: index 0 sets gain, index 1 sets deviation, others are
// ignored. Writes are meant for an idle block and apply to later samples.
// Reset clears the phase accumulator and all valid bits and restores the
// register reset values; the block is ready as soon as reset is released.
`default_nettype none

module fm_baseband_modulator (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [fmm_pkg::SAMPLE_W-1:0]    audio_sample_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [fmm_pkg::SAMPLE_W-1:0]    out_i_o,
  output logic [fmm_pkg::SAMPLE_W-1:0]    out_q_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [fmm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [fmm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fmm_pkg::*;

  logic                   advance;
  logic [GAIN_W-1:0]      gain_q;
  logic [DEV_W-1:0]       deviation_q;
  step_t                  step;
  logic [PHASE_W-1:0]     phase_d, phase_q;
  logic                   vld_c_q;
  logic [PHASE_W+ANG_W-1:0] phase_pad;
  logic [ANG_W-1:0]       ang, ang_quarter, ang_rot;
  cordic_vec_t            head;
  cordic_vec_t            chain [CORDIC_STAGES+1];
  cordic_vec_t            last;
  logic signed [XY_W-1:0] sin_r, cos_r, sin_c, cos_c;
  logic [SAMPLE_W-1:0]    out_i_d, out_q_d;
  logic                   out_valid_q;
  logic [SAMPLE_W-1:0]    out_i_q, out_q_q;

  // The pipeline moves unless a finished result is held by the receiver.
  assign advance     = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !advance;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RESET;
      deviation_q <= DEV_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_GAIN:      gain_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_DEVIATION: deviation_q <= cfg_data_i[DEV_W-1:0];
        default:       ;
      endcase
    end
  end

  fmm_step_gen u_step_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .valid_i     (in_valid_i),
    .sample_i    (audio_sample_i),
    .gain_i      (gain_q),
    .deviation_i (deviation_q),
    .step_o      (step)
  );

  // Phase accumulator: wraps modulo a full turn. It moves only for real samples.
  assign phase_d = step.neg ? phase_q - step.step : phase_q + step.step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      vld_c_q <= 1'b0;
    end else if (advance) begin
      vld_c_q <= step.valid;
      if (step.valid) begin
        phase_q <= phase_d;
      end
    end
  end

  // Angle in 2^-32 turn from the top of the phase. Angles in the left half
  // plane are turned by half a turn and the results negated at the end.
  always_comb begin
    phase_pad   = {phase_q, {ANG_W{1'b0}}};
    ang         = phase_pad[PHASE_W+ANG_W-1:PHASE_W];
    ang_quarter = ang + (ANG_W'(1) << (ANG_W - 2));
    ang_rot     = ang_quarter[ANG_W-1] ? ang + (ANG_W'(1) << (ANG_W - 1)) : ang;
    head.valid  = vld_c_q;
    head.flip   = ang_quarter[ANG_W-1];
    head.x      = CORDIC_X0;
    head.y      = '0;
    head.z      = Z_W'($signed(ang_rot));
  end

  assign chain[0] = head;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    fmm_cordic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .cell_idx_i (IDX_W'(g)),
      .atan_i     (ATAN_TURNS[g]),
      .vec_i      (chain[g]),
      .vec_o      (chain[g+1])
    );
  end

  assign last = chain[CORDIC_STAGES];

  // Round to Q1.15, clamp to symmetric full scale, undo the half-turn fold.
  always_comb begin
    sin_r = (last.y + OUT_RND) >>> OUT_SH;
    cos_r = (last.x + OUT_RND) >>> OUT_SH;
    sin_c = sin_r;
    cos_c = cos_r;
    if (sin_r > OUT_LIM) sin_c = OUT_LIM;
    if (sin_r < -OUT_LIM) sin_c = -OUT_LIM;
    if (cos_r > OUT_LIM) cos_c = OUT_LIM;
    if (cos_r < -OUT_LIM) cos_c = -OUT_LIM;
    if (last.flip) begin
      sin_c = -sin_c;
      cos_c = -cos_c;
    end
    out_i_d = sin_c[SAMPLE_W-1:0];
    out_q_d = cos_c[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_i_q <= out_i_d;
      out_q_q <= out_q_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

  // The accumulator only moves when a sample leaves the step generator.
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step.valid && advance) |=> $stable(phase_q))
    else $error("phase accumulator moved without a sample");

  // A result leaving the CORDIC chain lands in the output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && advance) |=> out_valid_o)
    else $error("result from the CORDIC chain was lost");

  // Outputs are clamped to symmetric full scale.
  a_out_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_i_o != FULL_SCALE) && (out_q_o != FULL_SCALE))
    else $error("output beyond symmetric full scale");

endmodule

`default_nettype wire

// ===== design/fmm_cordic_cell.sv =====
// One rotation cell of the CORDIC chain of the FM baseband modulator.
// Depends on fmm_pkg.
`default_nettype none

module fmm_cordic_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire [fmm_pkg::IDX_W-1:0]   cell_idx_i,
  input  wire [fmm_pkg::ANG_W-1:0]   atan_i,
  input  wire fmm_pkg::cordic_vec_t  vec_i,
  output fmm_pkg::cordic_vec_t       vec_o
);
  import fmm_pkg::*;

  cordic_vec_t            vec_d, vec_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atan_ext;

  always_comb begin
    // Arithmetic shifts floor toward minus infinity.
    dx       = vec_i.y >>> cell_idx_i;
    dy       = vec_i.x >>> cell_idx_i;
    atan_ext = $signed({{(Z_W - ANG_W){1'b0}}, atan_i});
    vec_d    = vec_i;
    if (vec_i.z >= 0) begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - atan_ext;
    end else begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + atan_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

// ===== design/fmm_step_gen.sv =====
// Two-stage phase step generator: gain scaling with clipping, then the
// deviation multiply with rounding. Depends on fmm_pkg.
`default_nettype none

module fmm_step_gen (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire [fmm_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire [fmm_pkg::GAIN_W-1:0]    gain_i,
  input  wire [fmm_pkg::DEV_W-1:0]     deviation_i,
  output fmm_pkg::step_t               step_o
);
  import fmm_pkg::*;

  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [AMP_PROD_W-1:0]    amp_prod;
  logic [AMP_PROD_W-1:0]    amp_round;
  logic [SAMPLE_W-1:0]      amp_d, amp_q;
  logic                     neg_a_q, vld_a_q;
  logic [STEP_PROD_W-1:0]   step_prod;
  logic [STEP_WIDE_W-1:0]   step_wide;
  step_t                    step_d, step_q;

  // Stage A: magnitude times gain, rounded half away from zero, clipped to 1.0.
  always_comb begin
    neg       = sample_i[SAMPLE_W-1];
    mag       = neg ? (MAG_W'(1) << SAMPLE_W) - MAG_W'(sample_i) : MAG_W'(sample_i);
    amp_prod  = AMP_PROD_W'(mag) * AMP_PROD_W'(gain_i);
    amp_round = (amp_prod + (AMP_PROD_W'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
    if (amp_round > AMP_PROD_W'(FULL_SCALE)) begin
      amp_d = FULL_SCALE;
    end else begin
      amp_d = amp_round[SAMPLE_W-1:0];
    end
  end

  // Stage B: amplitude times deviation, aligned to the phase LSB.
  always_comb begin
    step_prod = STEP_PROD_W'(amp_q) * STEP_PROD_W'(deviation_i);
    if (STEP_RSH > 0) begin
      step_prod = step_prod + (STEP_PROD_W'(1) << (STEP_RSH - 1));
    end
    step_wide    = (STEP_WIDE_W'(step_prod) >> STEP_RSH) << STEP_LSH;
    step_d.valid = vld_a_q;
    step_d.neg   = neg_a_q;
    step_d.step  = step_wide[PHASE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      step_q  <= '0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      amp_q   <= amp_d;
      neg_a_q <= neg;
    end
  end

  assign step_o = step_q;

endmodule

`default_nettype wire
